### hdl/rgbd_pkg.sv
// Shared types and pixel arithmetic for the RGB888 to RGB555 dither block.
`default_nettype none

package rgbd_pkg;

	localparam int unsigned DefLineWidth = 256;
	localparam int unsigned ChanW        = 8;
	localparam int unsigned Chan5W       = 5;
	localparam int unsigned ColorW       = 16;

	typedef logic [ChanW-1:0]  chan_t;
	typedef logic [Chan5W-1:0] chan5_t;
	typedef logic [ColorW-1:0] color_t;

	localparam chan_t DarkStep = chan_t'(4);

	// Pull a channel down by the dither step; small values stay as they are.
	function automatic chan_t darken(input chan_t c);
		darken = (c >= DarkStep) ? c - DarkStep : c;
	endfunction

	function automatic color_t pack555(input chan_t r, input chan_t g, input chan_t b);
		pack555 = {1'b1, b[ChanW-1 -: Chan5W], g[ChanW-1 -: Chan5W], r[ChanW-1 -: Chan5W]};
	endfunction

	// Lightness: (max+min)/2 of the three 5-bit channels, copied to all three.
	function automatic color_t to_gray(input color_t c);
		chan5_t           r;
		chan5_t           g;
		chan5_t           b;
		chan5_t           mx;
		chan5_t           mn;
		logic [Chan5W:0]  sum;
		chan5_t           l;
		r   = c[4:0];
		g   = c[9:5];
		b   = c[14:10];
		mx  = (b > g) ? b : g;
		mn  = (b < g) ? b : g;
		mx  = (mx > r) ? mx : r;
		mn  = (mn < r) ? mn : r;
		sum = {1'b0, mx} + {1'b0, mn};
		l   = sum[Chan5W:1];
		to_gray = {1'b1, l, l, l};
	endfunction

endpackage

`default_nettype wire

### hdl/rgbd_position.sv
// Column counter and checkerboard parity tracker, advanced once per accepted item.
`default_nettype none

module rgbd_position
	import rgbd_pkg::*;
#(
	parameter int unsigned LINE_WIDTH = DefLineWidth
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  advance,
	input  wire  image_start,
	output logic parity
);

	localparam int unsigned ColW = (LINE_WIDTH > 2) ? $clog2(LINE_WIDTH) : 1;
	localparam logic [ColW-1:0] LastCol = ColW'(LINE_WIDTH - 1);

	logic [ColW-1:0] column_q;
	logic [ColW-1:0] column_eff;
	logic            parity_q;
	logic            line_end;

	// image_start restarts the count before this item is placed
	assign column_eff = image_start ? '0 : column_q;
	assign line_end   = (column_eff >= LastCol);
	assign parity     = parity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			parity_q <= 1'b0;
		end else if (advance) begin
			if (line_end) begin
				column_q <= '0;
			end else begin
				column_q <= column_eff + ColW'(1);
				parity_q <= ~parity_q;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/rgbd_color.sv
// Per-pixel color path: darken, pack to 555, frame swap and optional grayscale.
`default_nettype none

module rgbd_color
	import rgbd_pkg::*;
(
	input  wire chan_t  red,
	input  wire chan_t  green,
	input  wire chan_t  blue,
	input  wire         parity,
	input  wire         gray_enable,
	output color_t      color_a,
	output color_t      color_b
);

	color_t raw;
	color_t dark;
	color_t ca;
	color_t cb;

	assign raw  = pack555(red, green, blue);
	assign dark = pack555(darken(red), darken(green), darken(blue));
	assign ca   = parity ? dark : raw;
	assign cb   = parity ? raw : dark;

	assign color_a = gray_enable ? to_gray(ca) : ca;
	assign color_b = gray_enable ? to_gray(cb) : cb;

endmodule

`default_nettype wire

### hdl/rgb888_to_rgb555_temporal_dither_top.sv
// Top level of the RGB888 to RGB555 converter with checkerboard temporal dither.
//
// Input channel: in_valid / in_stall with red_in, green_in, blue_in, image_start.
// Output channel: out_valid / out_stall with color_a and color_b, the two
// frame colors of one pixel (bit 15 set, blue 14:10, green 9:5, red 4:0).
// Config channel: cfg_valid / cfg_ready with cfg_data = gray_enable; cfg_ready
// is always high. Write it only while no item is in flight.
// An item is registered on entry and its colors computed into the output
// register: out_valid rises when the item moves on from the input register
// to the output register, which can wait while out_stall holds that register.
// Throughput is one item per clock while out_stall is low; column count and
// parity update at acceptance: back-to-back items need no later-stage feedback.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more; in_stall rises only when both are full.
// Reset (arst_n low) empties both registers, clears column and parity, and
// turns grayscale off.
`default_nettype none

module rgb888_to_rgb555_temporal_dither_top
	import rgbd_pkg::*;
#(
	parameter int unsigned LINE_WIDTH = DefLineWidth
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire chan_t  red_in,
	input  wire chan_t  green_in,
	input  wire chan_t  blue_in,
	input  wire         image_start,
	output logic        out_valid,
	input  wire         out_stall,
	output color_t      color_a,
	output color_t      color_b,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data
);

	logic   gray_q;
	logic   valid_s1;
	chan_t  red_s1;
	chan_t  green_s1;
	chan_t  blue_s1;
	logic   parity_s1;
	logic   valid_s2;
	color_t color_a_s2;
	color_t color_b_s2;
	logic   parity_now;
	logic   in_accept;
	logic   s2_load;
	color_t ca_next;
	color_t cb_next;

	assign cfg_ready = 1'b1;

	assign s2_load   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !s2_load;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			gray_q <= cfg_data;
		end
	end

	rgbd_position #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (in_accept),
		.image_start (image_start),
		.parity      (parity_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			red_s1    <= red_in;
			green_s1  <= green_in;
			blue_s1   <= blue_in;
			parity_s1 <= parity_now;
		end
	end

	rgbd_color u_color (
		.red         (red_s1),
		.green       (green_s1),
		.blue        (blue_s1),
		.parity      (parity_s1),
		.gray_enable (gray_q),
		.color_a     (ca_next),
		.color_b     (cb_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			color_a_s2 <= ca_next;
			color_b_s2 <= cb_next;
		end
	end

	assign out_valid = valid_s2;
	assign color_a   = color_a_s2;
	assign color_b   = color_b_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while a register stage was free");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_load && valid_s1) |=> out_valid)
		else $error("item lost between input and output register");

	a_s2_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_load && !valid_s1) |=> !out_valid)
		else $error("output shows an item that was never computed");

	a_color_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (color_a[ColorW-1] && color_b[ColorW-1]))
		else $error("result color missing its top flag bit");

endmodule

`default_nettype wire
